/* rtl/core/cps_pkg.sv */
// cpu process scheduler package: controller states, policy codes, command and status structs
// no dependencies
package cps_pkg;

    typedef enum logic [2:0] {
        POL_FCFS = 3'd0,
        POL_SJF  = 3'd1,
        POL_SRTF = 3'd2,
        POL_PRIO = 3'd3,
        POL_PPRI = 3'd4
    } t_policy;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD,
        ST_SCAN,
        ST_UPDATE,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic add_go;
        logic scan_start;
        logic scan_step;
        logic upd_start;
        logic upd_step;
        logic tick_commit;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic scan_last;
        logic upd_last;
        logic found;
    } t_status;

    localparam logic [23:0] T24_MAX = 24'hFFFFFF;

endpackage

/* rtl/core/cpu_process_scheduler_top.sv */
// cpu process scheduler top: an add result is valid in the cycle after its beat; a tick result
// follows ST_SCAN over all entries, ST_UPDATE, the ST_ADD waiting walk and ST_OUT; ST_ADD is
// skipped when nothing can run. one item in flight; the next beat is taken in the cycle the
// result beat leaves, so adds can follow every cycle while results are taken
// synchronous active-low reset clears entry count, time, policy (to preemptive priority)
// and control; table contents are written before being read; depends on cps_pkg, cps_ctrl, cps_datapath
module cpu_process_scheduler_top
    import cps_pkg::*;
#(
    parameter int MAX_PROCS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_action,
    input  logic [7:0]  i_proc_id,
    input  logic [15:0] i_burst,
    input  logic [7:0]  i_prio,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_accepted,
    output logic [3:0]  o_slot,
    output logic [7:0]  o_chosen_id,
    output logic [15:0] o_left,
    output logic        o_finished,
    output logic [23:0] o_finish_time,
    output logic [23:0] o_wait_total,
    output logic        o_all_done,
    output logic [23:0] o_now
);

    logic [2:0] r_policy;
    t_cmd       cmd;
    t_status    status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)      r_policy <= POL_PPRI;
        else if (i_cfg_we) r_policy <= i_cfg_wdata;
    end

    cps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_action   (i_action),
        .i_out_busy (o_out_valid && !i_out_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    cps_datapath #(.MAX_PROCS(MAX_PROCS)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_policy      (r_policy),
        .i_proc_id     (i_proc_id),
        .i_burst       (i_burst),
        .i_prio        (i_prio),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_accepted    (o_accepted),
        .o_slot        (o_slot),
        .o_chosen_id   (o_chosen_id),
        .o_left        (o_left),
        .o_finished    (o_finished),
        .o_finish_time (o_finish_time),
        .o_wait_total  (o_wait_total),
        .o_all_done    (o_all_done),
        .o_now         (o_now)
    );

endmodule

/* rtl/core/cps_datapath.sv */
// cpu process scheduler datapath: process table, serial selection scan, waiting update, result
// depends on cps_pkg
module cps_datapath
    import cps_pkg::*;
#(
    parameter int MAX_PROCS = 16,
    parameter int IW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1,
    parameter int CW = $clog2(MAX_PROCS + 1)
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_status     o_status,
    input  logic [2:0]  i_policy,
    input  logic [7:0]  i_proc_id,
    input  logic [15:0] i_burst,
    input  logic [7:0]  i_prio,
    input  logic        i_out_ready,
    output logic        o_out_valid,
    output logic        o_accepted,
    output logic [3:0]  o_slot,
    output logic [7:0]  o_chosen_id,
    output logic [15:0] o_left,
    output logic        o_finished,
    output logic [23:0] o_finish_time,
    output logic [23:0] o_wait_total,
    output logic        o_all_done,
    output logic [23:0] o_now
);

    logic [7:0]  r_ids     [MAX_PROCS];
    logic [23:0] r_arr     [MAX_PROCS];
    logic [15:0] r_orig    [MAX_PROCS];
    logic [15:0] r_rem     [MAX_PROCS];
    logic [23:0] r_wait    [MAX_PROCS];
    logic [7:0]  r_prios   [MAX_PROCS];
    logic [23:0] r_fin     [MAX_PROCS];
    logic [MAX_PROCS-1:0] r_done;
    logic [CW-1:0] r_count;
    logic [23:0] r_time;

    logic [IW-1:0] r_idx;
    logic [IW-1:0] r_best;
    logic          r_found;
    logic          r_valid;
    logic [CW-1:0] idx_ext;
    logic          in_range;
    logic          take;
    logic          live;
    logic [IW-1:0] b;
    logic [15:0]   rem_dec;
    logic [23:0]   time_inc;
    logic          any_live;
    logic          add_ok;

    assign idx_ext  = CW'(r_idx);
    assign in_range = idx_ext < r_count;
    assign live     = in_range && !r_done[r_idx];
    assign b        = r_best;
    assign o_status.scan_last = (idx_ext == CW'(MAX_PROCS - 1));
    assign o_status.upd_last  = (idx_ext == CW'(MAX_PROCS - 1));
    assign o_status.found     = r_found && (i_policy <= POL_PPRI);
    assign rem_dec  = (r_rem[b] != 16'd0) ? r_rem[b] - 16'd1 : 16'd0;
    assign time_inc = (r_time < T24_MAX) ? r_time + 24'd1 : r_time;
    assign add_ok   = (r_count < CW'(MAX_PROCS)) && (i_burst != 16'd0);

    always_comb begin
        unique case (i_policy)
            POL_FCFS: take = 1'b0;
            POL_SJF:  take = r_arr[r_idx] < r_arr[b] ||
                             (r_arr[r_idx] == r_arr[b] && r_orig[r_idx] < r_orig[b]);
            POL_SRTF: take = r_rem[r_idx] <= r_rem[b];
            POL_PRIO: take = r_arr[r_idx] < r_arr[b] ||
                             (r_arr[r_idx] == r_arr[b] && r_prios[r_idx] <= r_prios[b]);
            POL_PPRI: take = r_prios[r_idx] <= r_prios[b];
            default:  take = 1'b0;
        endcase
    end

    always_comb begin
        any_live = 1'b0;
        for (int k = 0; k < MAX_PROCS; k++)
            if (CW'(k) < r_count && !r_done[k]) any_live = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_time  <= '0;
            r_valid <= 1'b0;
            r_found <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (i_cmd.add_go) begin
                o_accepted    <= add_ok;
                o_slot        <= add_ok ? 4'(r_count) : 4'd0;
                o_chosen_id   <= '0;
                o_left        <= '0;
                o_finished    <= 1'b0;
                o_finish_time <= '0;
                o_wait_total  <= '0;
                if (add_ok) begin
                    r_ids[r_count[IW-1:0]]   <= i_proc_id;
                    r_arr[r_count[IW-1:0]]   <= r_time;
                    r_orig[r_count[IW-1:0]]  <= i_burst;
                    r_rem[r_count[IW-1:0]]   <= i_burst;
                    r_wait[r_count[IW-1:0]]  <= '0;
                    r_prios[r_count[IW-1:0]] <= i_prio;
                    r_done[r_count[IW-1:0]]  <= 1'b0;
                    r_fin[r_count[IW-1:0]]   <= '0;
                    r_count    <= r_count + CW'(1);
                end
            end
            if (i_cmd.scan_start) begin
                r_idx   <= '0;
                r_found <= 1'b0;
            end
            if (i_cmd.scan_step) begin
                if (live && (!r_found || take)) begin
                    if (!(r_found && i_policy == POL_FCFS)) r_best <= r_idx;
                    r_found <= 1'b1;
                end
                r_idx <= r_idx + IW'(1);
            end
            if (i_cmd.upd_start) r_idx <= '0;
            if (i_cmd.upd_step) begin
                if (live && r_ids[r_idx] != r_ids[b] && r_wait[r_idx] < T24_MAX)
                    r_wait[r_idx] <= r_wait[r_idx] + 24'd1;
                r_idx <= r_idx + IW'(1);
            end
            if (i_cmd.tick_commit) begin
                r_time <= time_inc;
                r_rem[b] <= rem_dec;
                if (rem_dec == 16'd0) begin
                    r_done[b] <= 1'b1;
                    r_fin[b]  <= time_inc;
                end
            end
            if (i_cmd.out_load) begin
                o_accepted    <= o_status.found;
                o_slot        <= o_status.found ? 4'(b) : 4'd0;
                o_chosen_id   <= o_status.found ? r_ids[b] : 8'd0;
                o_left        <= o_status.found ? r_rem[b] : 16'd0;
                o_finished    <= o_status.found && r_done[b];
                o_finish_time <= (o_status.found && r_done[b]) ? r_fin[b] : 24'd0;
                o_wait_total  <= o_status.found ? r_wait[b] : 24'd0;
            end
            if (i_cmd.out_load || i_cmd.add_go) r_valid <= 1'b1;
            else if (o_out_valid && i_out_ready) r_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_valid;
    assign o_all_done  = !any_live;
    assign o_now       = r_time;

endmodule

/* rtl/core/cps_ctrl.sv */
// cpu process scheduler controller: sequences add, scan, waiting update and result
// depends on cps_pkg
module cps_ctrl
    import cps_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  logic    i_action,
    input  logic    i_out_busy,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = !i_out_busy;
                if (i_in_valid && !i_out_busy) begin
                    if (i_action) begin
                        o_cmd.scan_start = 1'b1;
                        n_state = ST_SCAN;
                    end else begin
                        o_cmd.add_go = 1'b1;
                    end
                end
            end
            ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_status.scan_last) n_state = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (!i_status.found) n_state = ST_OUT;
                else begin
                    o_cmd.upd_start = 1'b1;
                    n_state = ST_ADD;
                end
            end
            ST_ADD: begin
                o_cmd.upd_step = 1'b1;
                if (i_status.upd_last) begin
                    o_cmd.tick_commit = 1'b1;
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                o_cmd.out_load = 1'b1;
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

/* test/cpu_process_scheduler_top_tb.sv */
// testbench for cpu_process_scheduler_top: directed and random add/tick beats under every policy
// predicts each result beat with its own scheduler table and checks it field by field
// depends on cps_pkg and cpu_process_scheduler_top
`timescale 1ns / 100ps

module cpu_process_scheduler_top_tb
    import cps_pkg::*;
();

    localparam int NPROC = 16;
    localparam int TICK_LAT = 2 * NPROC + 3;
    localparam int IDLE_LIMIT = 20000;
    localparam logic ACT_ADD = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    typedef struct packed {
        logic        accepted;
        logic [3:0]  slot;
        logic [7:0]  chosen_id;
        logic [15:0] left;
        logic        finished;
        logic [23:0] finish_time;
        logic [23:0] wait_total;
        logic        all_done;
        logic [23:0] now;
    } t_sched_res;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_wdata = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic        i_action = 1'b0;
    logic [7:0]  i_proc_id = '0;
    logic [15:0] i_burst = '0;
    logic [7:0]  i_prio = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic        o_accepted;
    logic [3:0]  o_slot;
    logic [7:0]  o_chosen_id;
    logic [15:0] o_left;
    logic        o_finished;
    logic [23:0] o_finish_time;
    logic [23:0] o_wait_total;
    logic        o_all_done;
    logic [23:0] o_now;

    cpu_process_scheduler_top #(.MAX_PROCS(NPROC)) dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // predictor state
    logic [7:0]  tb_ids [NPROC];
    logic [23:0] tb_arr [NPROC];
    logic [15:0] tb_orig [NPROC];
    logic [15:0] tb_rem [NPROC];
    logic [23:0] tb_wait [NPROC];
    logic [7:0]  tb_prio [NPROC];
    logic        tb_done [NPROC];
    int          tb_count;
    logic [23:0] tb_time;
    logic [2:0]  tb_policy;

    t_sched_res expected_q[$];
    int  fail_cnt = 0;
    int  idle_cycles = 0;
    bit  hold_rx = 1'b0;
    bit  fast_rx = 1'b0;

    task automatic sched_reset_model();
        tb_count = 0;
        tb_time = '0;
        tb_policy = POL_PPRI;
    endtask

    function automatic int pick_next();
        int best;
        bit take;
        best = -1;
        for (int k = 0; k < tb_count; k++) begin
            if (tb_done[k]) continue;
            if (best < 0) begin
                best = k;
                if (tb_policy == POL_FCFS) break;
                continue;
            end
            take = 1'b0;
            case (tb_policy)
                POL_SJF: take = tb_arr[k] < tb_arr[best] ||
                    (tb_arr[k] == tb_arr[best] && tb_orig[k] < tb_orig[best]);
                POL_SRTF: take = tb_rem[k] <= tb_rem[best];
                POL_PRIO: take = tb_arr[k] < tb_arr[best] ||
                    (tb_arr[k] == tb_arr[best] && tb_prio[k] <= tb_prio[best]);
                POL_PPRI: take = tb_prio[k] <= tb_prio[best];
                default: take = 1'b0;
            endcase
            if (take) best = k;
        end
        if (tb_policy > POL_PPRI) best = -1;
        return best;
    endfunction

    function automatic t_sched_res schedule_beat(logic act, logic [7:0] pid,
                                                 logic [15:0] bst, logic [7:0] pr);
        t_sched_res r;
        int c;
        r = '0;
        if (act == ACT_ADD) begin
            if (tb_count < NPROC && bst != 0) begin
                tb_ids[tb_count] = pid;
                tb_arr[tb_count] = tb_time;
                tb_orig[tb_count] = bst;
                tb_rem[tb_count] = bst;
                tb_wait[tb_count] = '0;
                tb_prio[tb_count] = pr;
                tb_done[tb_count] = 1'b0;
                r.accepted = 1'b1;
                r.slot = tb_count[3:0];
                tb_count++;
            end
        end else begin
            c = pick_next();
            if (c >= 0) begin
                if (tb_time != T24_MAX) tb_time++;
                for (int k = 0; k < tb_count; k++)
                    if (tb_ids[k] != tb_ids[c] && !tb_done[k] && tb_wait[k] != T24_MAX)
                        tb_wait[k]++;
                if (tb_rem[c] != 0) tb_rem[c]--;
                if (tb_rem[c] == 0) tb_done[c] = 1'b1;
                r.accepted = 1'b1;
                r.slot = c[3:0];
                r.chosen_id = tb_ids[c];
                r.left = tb_rem[c];
                r.finished = tb_rem[c] == 0;
                r.finish_time = r.finished ? tb_time : '0;
                r.wait_total = tb_wait[c];
            end
        end
        r.all_done = 1'b1;
        for (int k = 0; k < tb_count; k++)
            if (!tb_done[k]) r.all_done = 1'b0;
        r.now = tb_time;
        return r;
    endfunction

    function automatic int rand_gap();
        if ($urandom_range(9) < 7) return 0;
        if ($urandom_range(9) < 8) return $urandom_range(3);
        return $urandom_range(40);
    endfunction

    task automatic send_beat(logic act, logic [7:0] pid, logic [15:0] bst, logic [7:0] pr);
        int gap;
        gap = fast_rx ? 0 : rand_gap();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action <= act;
        i_proc_id <= pid;
        i_burst <= bst;
        i_prio <= pr;
        @(negedge i_clk);
        while (!o_in_ready) @(negedge i_clk);
        @(posedge i_clk);
        expected_q = {expected_q, schedule_beat(act, pid, bst, pr)};
    endtask

    task automatic drain_and_config(logic [2:0] pol);
        i_in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (TICK_LAT + 4) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= pol;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        tb_policy = pol;
    endtask

    task automatic rand_add();
        logic [15:0] b;
        case ($urandom_range(7))
            0: b = 16'd0;
            1: b = 16'hFFFF;
            default: b = 16'($urandom_range(1, 6));
        endcase
        send_beat(ACT_ADD, 8'($urandom_range(0, 255)), b, 8'($urandom_range(0, 255)));
    endtask

    task automatic test_directed();
        drain_and_config(POL_FCFS);
        send_beat(ACT_TICK, 8'h00, 16'h0000, 8'h00);
        send_beat(ACT_ADD, 8'hFF, 16'h0000, 8'hFF);
        send_beat(ACT_ADD, 8'hFF, 16'hFFFF, 8'hFF);
        send_beat(ACT_ADD, 8'h00, 16'h0001, 8'h00);
        send_beat(ACT_ADD, 8'h00, 16'h0002, 8'h00);
        send_beat(ACT_TICK, 8'hFF, 16'hFFFF, 8'hFF);
        drain_and_config(POL_SJF);
        send_beat(ACT_TICK, 8'h00, 16'h0000, 8'h00);
        send_beat(ACT_TICK, 8'h00, 16'h0000, 8'h00);
        drain_and_config(POL_SRTF);
        send_beat(ACT_TICK, 8'h00, 16'h0000, 8'h00);
        drain_and_config(POL_PRIO);
        send_beat(ACT_TICK, 8'h00, 16'h0000, 8'h00);
        drain_and_config(3'd7);
        send_beat(ACT_TICK, 8'h00, 16'h0000, 8'h00);
        drain_and_config(3'd5);
        send_beat(ACT_TICK, 8'h00, 16'h0000, 8'h00);
        drain_and_config(POL_PPRI);
        for (int k = 0; k < 14; k++) send_beat(ACT_ADD, 8'h00, 16'h0001, 8'h80);
        send_beat(ACT_ADD, 8'h01, 16'h0003, 8'h80);
        send_beat(ACT_TICK, 8'h00, 16'h0000, 8'h00);
        send_beat(ACT_TICK, 8'h00, 16'h0000, 8'h00);
    endtask

    // table is full after the directed test, so adds here are rejected while ticks run it down
    task automatic test_random(int n_items);
        logic [2:0] pol;
        for (int i = 0; i < n_items; i++) begin
            if (i % 120 == 0) begin
                pol = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                                  : 3'($urandom_range(0, 4));
                drain_and_config(pol);
            end
            if ($urandom_range(3) == 0) rand_add();
            else send_beat($urandom_range(9) == 0 ? ACT_ADD : ACT_TICK,
                           8'($urandom_range(0, 255)), 16'($urandom_range(0, 3)),
                           8'($urandom_range(0, 255)));
        end
    endtask

    task automatic test_backpressure();
        fast_rx = 1'b1;
        hold_rx = 1'b1;
        fork
            begin
                repeat (300) @(posedge i_clk);
                hold_rx = 1'b0;
            end
            for (int k = 0; k < 6; k++) send_beat(ACT_TICK, 8'h00, 16'h0000, 8'h00);
        join
        fast_rx = 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n || hold_rx) i_out_ready <= 1'b0;
        else if ($urandom_range(9) < 3) i_out_ready <= 1'b1;
        else if ($urandom_range(19) == 0) i_out_ready <= 1'b0;
        else i_out_ready <= fast_rx | ($urandom_range(3) != 0);
    end

    always @(posedge i_clk) begin
        t_sched_res got;
        t_sched_res exp;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = '{o_accepted, o_slot, o_chosen_id, o_left, o_finished, o_finish_time,
                    o_wait_total, o_all_done, o_now};
            if (expected_q.size() == 0) begin
                $error("result beat with nothing expected");
                fail_cnt++;
            end else begin
                exp = expected_q.pop_front();
                if (got.accepted != exp.accepted) begin
                    $error("accepted exp %0h got %0h", exp.accepted, got.accepted); fail_cnt++;
                end
                if (got.slot != exp.slot) begin
                    $error("slot exp %0h got %0h", exp.slot, got.slot); fail_cnt++;
                end
                if (got.chosen_id != exp.chosen_id) begin
                    $error("chosen_id exp %0h got %0h", exp.chosen_id, got.chosen_id);
                    fail_cnt++;
                end
                if (got.left != exp.left) begin
                    $error("left exp %0h got %0h", exp.left, got.left); fail_cnt++;
                end
                if (got.finished != exp.finished) begin
                    $error("finished exp %0h got %0h", exp.finished, got.finished); fail_cnt++;
                end
                if (got.finish_time != exp.finish_time) begin
                    $error("finish_time exp %0h got %0h", exp.finish_time, got.finish_time);
                    fail_cnt++;
                end
                if (got.wait_total != exp.wait_total) begin
                    $error("wait_total exp %0h got %0h", exp.wait_total, got.wait_total);
                    fail_cnt++;
                end
                if (got.all_done != exp.all_done) begin
                    $error("all_done exp %0h got %0h", exp.all_done, got.all_done); fail_cnt++;
                end
                if (got.now != exp.now) begin
                    $error("now exp %0h got %0h", exp.now, got.now); fail_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        sched_reset_model();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_backpressure();
        test_random(1420);
        i_in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (TICK_LAT + 10) @(posedge i_clk);
        if (fail_cnt == 0 && expected_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
